// ----- hw/rtl/tsa_pkg.sv -----
// Shared types, constants and helper functions for the tile span allocator.
// Used by every module under hw/rtl; depends on nothing else.
package tsa_pkg;

  localparam int COORD_W    = 32;                       // Q16.16 coordinates
  localparam int FRAC_BITS  = 16;                       // fraction bits of coords and factor
  localparam int ALIGN_W    = 17;                       // Q1.16 alignment, one = 65536
  localparam int ALIGN_FRAC = 16;
  localparam logic [ALIGN_W-1:0] ALIGN_ONE = ALIGN_W'(1) << ALIGN_FRAC;

  localparam int FACTOR_W  = 32;
  localparam int MAG_W     = COORD_W + 1;               // magnitude of a coordinate difference
  localparam int LEN_W     = MAG_W + 1;                 // signed usable length
  localparam int CMP_W     = 2 * ALIGN_W;               // product of two alignments
  localparam int DIV_W     = MAG_W + FRAC_BITS;         // divider dividend and quotient
  localparam int DVS_W     = MAG_W;                     // divider divisor
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int MUL_A_W   = MAG_W;
  localparam int MUL_B_W   = FACTOR_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = MAG_W - FRAC_BITS + FACTOR_W;
  localparam int WIDE_W    = DIV_W + 3;                 // signed working width
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic                        first_cell;
    logic                        cell_defined;
    logic signed [COORD_W-1:0]   cell_natural;
    logic signed [COORD_W-1:0]   cell_minimum;
    logic signed [COORD_W-1:0]   cell_maximum;
    logic        [ALIGN_W-1:0]   cell_align;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]   span_lower;
    logic signed [COORD_W-1:0]   span_upper;
    logic        [ALIGN_W-1:0]   span_align;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_NATURAL = 3'd0,
    CFG_TOTAL_MINIMUM = 3'd1,
    CFG_TOTAL_MAXIMUM = 3'd2,
    CFG_TOTAL_ALIGN   = 3'd3,
    CFG_REGION_BEGIN  = 3'd4,
    CFG_REGION_END    = 3'd5,
    CFG_REGION_ALIGN  = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_RATIO_A,
    OP_RATIO_B,
    OP_RATIO_C,
    OP_LEN_MUL,
    OP_LEN_DIV,
    OP_LEN_SET,
    OP_POS_MUL,
    OP_POS_SET,
    OP_FAC_DIV,
    OP_FAC_SET,
    OP_CELL_PREP,
    OP_CELL_HI,
    OP_CELL_LO,
    OP_CELL_SUM,
    OP_PLACE
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_RATIO_A,
    S_RATIO_B,
    S_RATIO_C,
    S_LEN_MUL,
    S_LEN_DIV,
    S_LEN_WAIT,
    S_LEN_SET,
    S_POS_MUL,
    S_POS_SET,
    S_FAC_DIV,
    S_FAC_WAIT,
    S_FAC_SET,
    S_CELL_PREP,
    S_CELL_HI,
    S_CELL_LO,
    S_CELL_SUM,
    S_PLACE
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic first_cell;
    logic cell_defined;
    logic div_busy;
    logic fac_needed;
    logic out_free;
  } status_t;

  function automatic logic signed [WIDE_W-1:0] sext_coord(input logic signed [COORD_W-1:0] v);
    sext_coord = {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_W:0] top;
    top = v[WIDE_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  function automatic logic [ALIGN_W-1:0] clamp_align(input logic [ALIGN_W-1:0] v);
    clamp_align = (v > ALIGN_ONE) ? ALIGN_ONE : v;
  endfunction

endpackage

// ----- hw/rtl/tsa_divider.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on tsa_pkg for its widths.
module tsa_divider
  import tsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;

  // The quotient shifts in where the dividend shifts out.
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = DIV_CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

// ----- hw/rtl/tsa_datapath.sv -----
// Datapath of the tile span allocator: configuration registers, pass state,
// shared multiplier, divider and the result register. Depends on tsa_pkg and tsa_divider.
module tsa_datapath
  import tsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // Configuration registers
  logic signed [COORD_W-1:0] tot_nat_r, tot_nat_nxt;
  logic signed [COORD_W-1:0] tot_min_r, tot_min_nxt;
  logic signed [COORD_W-1:0] tot_max_r, tot_max_nxt;
  logic        [ALIGN_W-1:0] tot_align_r, tot_align_nxt;
  logic signed [COORD_W-1:0] reg_begin_r, reg_begin_nxt;
  logic signed [COORD_W-1:0] reg_end_r, reg_end_nxt;
  logic        [ALIGN_W-1:0] reg_align_r, reg_align_nxt;

  // Pass state
  logic signed [COORD_W-1:0] position_r, position_nxt;
  logic [FACTOR_W-1:0]       factor_r, factor_nxt;
  logic                      grow_r, grow_nxt;
  logic                      shrink_r, shrink_nxt;

  // Working registers
  in_item_t                  item_r, item_nxt;
  logic [ALIGN_W-1:0]        ra_r, ra_nxt;
  logic [ALIGN_W-1:0]        aa_r, aa_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [CMP_W-1:0]          cmp_r, cmp_nxt;
  logic [ALIGN_W-1:0]        num_r, num_nxt;
  logic [ALIGN_W-1:0]        den_r, den_nxt;
  logic signed [LEN_W-1:0]   length_r, length_nxt;
  logic                      fac_need_r, fac_need_nxt;
  logic [MAG_W-1:0]          fac_num_r, fac_num_nxt;
  logic [DVS_W-1:0]          fac_den_r, fac_den_nxt;
  logic [MAG_W-1:0]          xmag_r, xmag_nxt;
  logic                      xneg_r, xneg_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [COORD_W-1:0] size_r, size_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  // Multiplier and divider hookup
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_en;
  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DVS_W-1:0]          div_divisor;
  logic                      div_busy;
  logic [DIV_W-1:0]          div_quo;

  // Intermediate values
  logic [ALIGN_W-1:0]        one_m_ra, one_m_aa;
  logic signed [WIDE_W-1:0]  len0_w, len_abs_w;
  logic signed [WIDE_W-1:0]  quo_w, length_w;
  logic signed [WIDE_W-1:0]  pos_off_w, pos_sum_w;
  logic signed [WIDE_W-1:0]  len_x_w, nat_w, min_w, max_w;
  logic signed [WIDE_W-1:0]  up_num_w, dn_num_w, up_den_w, dn_den_w;
  logic                      is_grow, is_shrink;
  logic signed [WIDE_W-1:0]  x_w, x_abs_w;
  logic signed [WIDE_W-1:0]  cnat_w, p_w, delta_w, size_w;
  logic signed [WIDE_W-1:0]  place_w;
  logic signed [COORD_W-1:0] upper_c;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign one_m_ra  = ALIGN_ONE - ra_r;
  assign one_m_aa  = ALIGN_ONE - aa_r;
  assign len0_w    = sext_coord(reg_end_r) - sext_coord(reg_begin_r);
  assign len_abs_w = len0_w[WIDE_W-1] ? -len0_w : len0_w;

  assign quo_w     = {{(WIDE_W-MAG_W){1'b0}}, div_quo[MAG_W-1:0]};
  assign length_w  = neg_r ? -quo_w : quo_w;

  // The aligned origin: begin plus the length scaled by the region alignment.
  assign pos_off_w = {{(WIDE_W-MAG_W){1'b0}}, prod_r[ALIGN_FRAC+MAG_W-1:ALIGN_FRAC]};
  assign pos_sum_w = sext_coord(reg_begin_r) + (neg_r ? -pos_off_w : pos_off_w);

  assign len_x_w   = {{(WIDE_W-LEN_W){length_r[LEN_W-1]}}, length_r};
  assign nat_w     = sext_coord(tot_nat_r);
  assign min_w     = sext_coord(tot_min_r);
  assign max_w     = sext_coord(tot_max_r);
  assign up_num_w  = len_x_w - nat_w;
  assign dn_num_w  = nat_w - len_x_w;
  assign up_den_w  = max_w - nat_w;
  assign dn_den_w  = nat_w - min_w;
  assign is_grow   = (len_x_w > nat_w);
  assign is_shrink = (len_x_w < nat_w);

  assign cnat_w    = sext_coord(item_r.cell_natural);
  assign x_w       = grow_r ? (sext_coord(item_r.cell_maximum) - cnat_w)
                            : (cnat_w - sext_coord(item_r.cell_minimum));
  assign x_abs_w   = x_w[WIDE_W-1] ? -x_w : x_w;

  // Product of magnitude and factor, split at the binary point.
  assign p_w       = {{(WIDE_W-ACC_W){1'b0}}, acc_r}
                   + {{(WIDE_W-FACTOR_W){1'b0}}, prod_r[FRAC_BITS+FACTOR_W-1:FRAC_BITS]};
  assign delta_w   = xneg_r ? -p_w : p_w;
  assign size_w    = grow_r ? (cnat_w + delta_w) : (shrink_r ? (cnat_w - delta_w) : cnat_w);

  assign place_w   = sext_coord(position_r) + sext_coord(size_r);
  assign upper_c   = sat_coord(place_w);

  always_comb begin
    tot_nat_nxt   = tot_nat_r;
    tot_min_nxt   = tot_min_r;
    tot_max_nxt   = tot_max_r;
    tot_align_nxt = tot_align_r;
    reg_begin_nxt = reg_begin_r;
    reg_end_nxt   = reg_end_r;
    reg_align_nxt = reg_align_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_NATURAL: tot_nat_nxt   = cfg_data;
        CFG_TOTAL_MINIMUM: tot_min_nxt   = cfg_data;
        CFG_TOTAL_MAXIMUM: tot_max_nxt   = cfg_data;
        CFG_TOTAL_ALIGN:   tot_align_nxt = cfg_data[ALIGN_W-1:0];
        CFG_REGION_BEGIN:  reg_begin_nxt = cfg_data;
        CFG_REGION_END:    reg_end_nxt   = cfg_data;
        CFG_REGION_ALIGN:  reg_align_nxt = cfg_data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    position_nxt  = position_r;
    factor_nxt    = factor_r;
    grow_nxt      = grow_r;
    shrink_nxt    = shrink_r;
    item_nxt      = item_r;
    ra_nxt        = ra_r;
    aa_nxt        = aa_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cmp_nxt       = cmp_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    length_nxt    = length_r;
    fac_need_nxt  = fac_need_r;
    fac_num_nxt   = fac_num_r;
    fac_den_nxt   = fac_den_r;
    xmag_nxt      = xmag_r;
    xneg_nxt      = xneg_r;
    acc_nxt       = acc_r;
    size_nxt      = size_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dividend  = prod_r[DIV_W-1:0];
    div_divisor   = {{(DVS_W-ALIGN_W){1'b0}}, den_r};

    case (cmd.op)
      OP_LOAD: begin
        item_nxt = in_data;
      end
      OP_PREP: begin
        ra_nxt  = clamp_align(tot_align_r);
        aa_nxt  = clamp_align(reg_align_r);
        neg_nxt = len0_w[WIDE_W-1];
        mag_nxt = len_abs_w[MAG_W-1:0];
      end
      OP_RATIO_A: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_A_W-ALIGN_W){1'b0}}, aa_r};
        mul_b  = {{(MUL_B_W-ALIGN_W){1'b0}}, one_m_ra};
      end
      OP_RATIO_B: begin
        cmp_nxt = prod_r[CMP_W-1:0];
        mul_en  = 1'b1;
        mul_a   = {{(MUL_A_W-ALIGN_W){1'b0}}, one_m_aa};
        mul_b   = {{(MUL_B_W-ALIGN_W){1'b0}}, ra_r};
      end
      OP_RATIO_C: begin
        // Pick the smaller of the two alignment ratios by cross-multiplication.
        if (ra_r == '0) begin
          num_nxt = one_m_aa;
          den_nxt = ALIGN_ONE;
        end else if (ra_r == ALIGN_ONE) begin
          num_nxt = aa_r;
          den_nxt = ALIGN_ONE;
        end else if (cmp_r <= prod_r[CMP_W-1:0]) begin
          num_nxt = aa_r;
          den_nxt = ra_r;
        end else begin
          num_nxt = one_m_aa;
          den_nxt = one_m_ra;
        end
      end
      OP_LEN_MUL: begin
        mul_en = 1'b1;
        mul_a  = mag_r;
        mul_b  = {{(MUL_B_W-ALIGN_W){1'b0}}, num_r};
      end
      OP_LEN_DIV: begin
        div_start = 1'b1;
      end
      OP_LEN_SET: begin
        length_nxt = length_w[LEN_W-1:0];
      end
      OP_POS_MUL: begin
        mul_en = 1'b1;
        mul_a  = mag_r;
        mul_b  = {{(MUL_B_W-ALIGN_W){1'b0}}, aa_r};
      end
      OP_POS_SET: begin
        position_nxt = sat_coord(pos_sum_w);
        grow_nxt     = is_grow;
        shrink_nxt   = is_shrink;
        factor_nxt   = '0;
        fac_need_nxt = 1'b0;
        if (is_grow && (max_w > nat_w)) begin
          fac_need_nxt = 1'b1;
          fac_num_nxt  = up_num_w[MAG_W-1:0];
          fac_den_nxt  = up_den_w[DVS_W-1:0];
        end else if (is_shrink && (min_w < nat_w)) begin
          fac_need_nxt = 1'b1;
          fac_num_nxt  = dn_num_w[MAG_W-1:0];
          fac_den_nxt  = dn_den_w[DVS_W-1:0];
        end
      end
      OP_FAC_DIV: begin
        div_start    = 1'b1;
        div_dividend = {fac_num_r, {FRAC_BITS{1'b0}}};
        div_divisor  = fac_den_r;
      end
      OP_FAC_SET: begin
        factor_nxt = (|div_quo[DIV_W-1:FACTOR_W]) ? '1 : div_quo[FACTOR_W-1:0];
      end
      OP_CELL_PREP: begin
        xneg_nxt = x_w[WIDE_W-1];
        xmag_nxt = x_abs_w[MAG_W-1:0];
      end
      OP_CELL_HI: begin
        mul_en = 1'b1;
        mul_a  = {{FRAC_BITS{1'b0}}, xmag_r[MAG_W-1:FRAC_BITS]};
        mul_b  = factor_r;
      end
      OP_CELL_LO: begin
        acc_nxt = prod_r[ACC_W-1:0];
        mul_en  = 1'b1;
        mul_a   = {{(MUL_A_W-FRAC_BITS){1'b0}}, xmag_r[FRAC_BITS-1:0]};
        mul_b   = factor_r;
      end
      OP_CELL_SUM: begin
        size_nxt = sat_coord(size_w);
      end
      OP_PLACE: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.span_lower = position_r;
        if (item_r.cell_defined) begin
          out_data_nxt.span_upper = upper_c;
          out_data_nxt.span_align = clamp_align(item_r.cell_align);
          position_nxt            = upper_c;
        end else begin
          out_data_nxt.span_upper = position_r;
          out_data_nxt.span_align = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_nxt = prod_r;
    if (mul_en) begin
      prod_nxt = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
    end
  end

  tsa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_nat_r   <= '0;
      tot_min_r   <= '0;
      tot_max_r   <= '0;
      tot_align_r <= '0;
      reg_begin_r <= '0;
      reg_end_r   <= '0;
      reg_align_r <= '0;
      position_r  <= '0;
      factor_r    <= '0;
      grow_r      <= 1'b0;
      shrink_r    <= 1'b0;
      fac_need_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tot_nat_r   <= tot_nat_nxt;
      tot_min_r   <= tot_min_nxt;
      tot_max_r   <= tot_max_nxt;
      tot_align_r <= tot_align_nxt;
      reg_begin_r <= reg_begin_nxt;
      reg_end_r   <= reg_end_nxt;
      reg_align_r <= reg_align_nxt;
      position_r  <= position_nxt;
      factor_r    <= factor_nxt;
      grow_r      <= grow_nxt;
      shrink_r    <= shrink_nxt;
      fac_need_r  <= fac_need_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ra_r       <= ra_nxt;
    aa_r       <= aa_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    cmp_r      <= cmp_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    length_r   <= length_nxt;
    fac_num_r  <= fac_num_nxt;
    fac_den_r  <= fac_den_nxt;
    xmag_r     <= xmag_nxt;
    xneg_r     <= xneg_nxt;
    acc_r      <= acc_nxt;
    size_r     <= size_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.first_cell   = item_r.first_cell;
  assign status.cell_defined = item_r.cell_defined;
  assign status.div_busy     = div_busy;
  assign status.fac_needed   = fac_need_r;
  assign status.out_free     = out_free;

`ifndef SYNTHESIS
  a_place_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PLACE) |-> out_free)
    else $error("result written while the previous one is still held");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_place_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PLACE) |=> out_valid_r)
    else $error("placed span not presented");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(grow_r && shrink_r))
    else $error("row both growing and shrinking");
`endif

endmodule

// ----- hw/rtl/tsa_control.sv -----
// Controller of the tile span allocator: sequences a pass start and the
// placement of each cell. Depends on tsa_pkg; drives the datapath by command.
module tsa_control
  import tsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (status.first_cell) begin
          cmd.op    = OP_PREP;
          state_nxt = S_RATIO_A;
        end else begin
          cmd.op    = OP_CELL_PREP;
          state_nxt = status.cell_defined ? S_CELL_HI : S_PLACE;
        end
      end
      S_RATIO_A: begin
        cmd.op    = OP_RATIO_A;
        state_nxt = S_RATIO_B;
      end
      S_RATIO_B: begin
        cmd.op    = OP_RATIO_B;
        state_nxt = S_RATIO_C;
      end
      S_RATIO_C: begin
        cmd.op    = OP_RATIO_C;
        state_nxt = S_LEN_MUL;
      end
      S_LEN_MUL: begin
        cmd.op    = OP_LEN_MUL;
        state_nxt = S_LEN_DIV;
      end
      S_LEN_DIV: begin
        cmd.op    = OP_LEN_DIV;
        state_nxt = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_LEN_SET;
        end
      end
      S_LEN_SET: begin
        cmd.op    = OP_LEN_SET;
        state_nxt = S_POS_MUL;
      end
      S_POS_MUL: begin
        cmd.op    = OP_POS_MUL;
        state_nxt = S_POS_SET;
      end
      S_POS_SET: begin
        cmd.op    = OP_POS_SET;
        state_nxt = S_FAC_DIV;
      end
      S_FAC_DIV: begin
        // With no room to stretch or shrink the factor stays zero.
        if (status.fac_needed) begin
          cmd.op    = OP_FAC_DIV;
          state_nxt = S_FAC_WAIT;
        end else begin
          state_nxt = S_CELL_PREP;
        end
      end
      S_FAC_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_FAC_SET;
        end
      end
      S_FAC_SET: begin
        cmd.op    = OP_FAC_SET;
        state_nxt = S_CELL_PREP;
      end
      S_CELL_PREP: begin
        cmd.op    = OP_CELL_PREP;
        state_nxt = status.cell_defined ? S_CELL_HI : S_PLACE;
      end
      S_CELL_HI: begin
        cmd.op    = OP_CELL_HI;
        state_nxt = S_CELL_LO;
      end
      S_CELL_LO: begin
        cmd.op    = OP_CELL_LO;
        state_nxt = S_CELL_SUM;
      end
      S_CELL_SUM: begin
        cmd.op    = OP_CELL_SUM;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        if (status.out_free) begin
          cmd.op    = OP_PLACE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tile_span_allocator.sv -----
// Tile span allocator top level: joins the controller and the datapath.
// Depends on tsa_pkg, tsa_control, tsa_datapath and tsa_divider.
//
// Use: write the row totals and the allotted region through the cfg_ port
// (index as listed in cfg_idx_t, cfg_ready is always high) while no request
// is in flight. Each request on in_ describes one cell; first_cell set starts
// a new pass. Each request gives exactly one span on out_, in order.
// Flow: a first cell first sets up the pass, in which the usable length and the
// squeeze factor each go through the shared 49-step restoring divider, the
// second division being skipped when the factor is zero. A defined cell then
// has its size worked out through the multiplier before it is placed; an
// undefined cell is placed with zero size at the running position.
// One request is worked on at a time; a new request may be accepted while the
// previous span still waits in the output register, but the next span is only
// written once that register has been taken. While out_stall is high a valid
// span and out_valid hold.
// Reset (rst_n low, synchronous) clears the configuration registers, the
// running position, the factor and the grow/shrink flags to zero.
module tile_span_allocator
  import tsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t status;

  tsa_control u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  tsa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
